@@ design/two_class_priority_queue_assert.svh @@
// Assertion macros shared by the two-class priority queue modules.
`ifndef TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define TCPQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcpq assertion failed");
// Checked property, active during reset as well.
`define TCPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcpq assertion failed");
`else
`define TCPQ_ASSERT(lbl, clk, rst, prop)
`define TCPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ design/tcpq_pkg.sv @@
// Shared types and constants for the two-class priority queue.
`default_nettype none

package tcpq_pkg;

  localparam int DEF_DEPTH      = 8;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int ACT_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // priority classes
  localparam logic CLASS_HIGH = 1'b0;
  localparam logic CLASS_LOW  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } tcpq_state_t;

  // where the result word comes from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_NEG1,
    SRC_HIGH,
    SRC_LOW
  } tcpq_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic exec;     // run the queued operation
  } tcpq_cmd_t;

endpackage

`default_nettype wire

@@ design/tcpq_ctrl.sv @@
// Controller state machine: accepts a transaction, runs it, presents the result.
`default_nettype none
`include "two_class_priority_queue_assert.svh"

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  output logic           done,
  output tcpq_cmd_t      cmd
);

  tcpq_state_t state;
  tcpq_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    done        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = start;
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // result goes out while the next transaction may come in
        done        = 1'b1;
        cmd.capture = start;
        state_next  = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `TCPQ_ASSERT(a_exec_then_resp, clk, rst, busy |=> done)
  `TCPQ_ASSERT(a_done_after_exec, clk, rst, done |-> $past(cmd.exec))
  `TCPQ_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done)

endmodule

`default_nettype wire

@@ design/tcpq_datapath.sv @@
// Datapath: two ring-buffer FIFOs with strict-priority selection of the result.
`default_nettype none
`include "two_class_priority_queue_assert.svh"

module tcpq_datapath
  import tcpq_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tcpq_cmd_t                  cmd,
  input  wire logic [ACT_W-1:0]           action,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic                       priority_req,
  output logic signed [VALUE_W-1:0]       result_value,
  output logic [STATUS_W-1:0]             status,
  output logic                            served_class
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // storage
  logic [DATA_WIDTH-1:0] high_mem [DEPTH];
  logic [DATA_WIDTH-1:0] low_mem  [DEPTH];

  // latched transaction
  logic [ACT_W-1:0]      op_action;
  logic [DATA_WIDTH-1:0] op_word;
  logic                  op_class;

  // ring pointers and fill counts
  logic [PTR_W-1:0] high_rptr;
  logic [PTR_W-1:0] high_wptr;
  logic [CNT_W-1:0] high_count;
  logic [PTR_W-1:0] low_rptr;
  logic [PTR_W-1:0] low_wptr;
  logic [CNT_W-1:0] low_count;

  // result registers
  logic signed [DATA_WIDTH-1:0] rd_high;
  logic signed [DATA_WIDTH-1:0] rd_low;
  tcpq_src_t                    res_src;
  logic [STATUS_W-1:0]          res_status;
  logic                         res_class;

  // operation decode
  tcpq_src_t           src_next;
  logic [STATUS_W-1:0] status_next;
  logic                class_next;
  logic                high_push;
  logic                high_pop;
  logic                low_push;
  logic                low_pop;

  // capture the incoming transaction; store only the low DATA_WIDTH bits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_action <= action;
      op_word   <= DATA_WIDTH'($unsigned(value));
      op_class  <= priority_req;
    end
  end

  // decide push/pop and the result source
  always_comb begin
    src_next    = SRC_ZERO;
    status_next = ST_OK;
    class_next  = CLASS_HIGH;
    high_push   = 1'b0;
    high_pop    = 1'b0;
    low_push    = 1'b0;
    low_pop     = 1'b0;
    unique case (op_action) inside
      ACT_ENQ: begin
        class_next = op_class;
        if (op_class == CLASS_HIGH) begin
          if (high_count == FULL_CNT) status_next = ST_FULL;
          else high_push = 1'b1;
        end else begin
          if (low_count == FULL_CNT) status_next = ST_FULL;
          else low_push = 1'b1;
        end
      end
      ACT_DEQ, ACT_PEEK: begin
        if (high_count != '0) begin
          src_next = SRC_HIGH;
          high_pop = (op_action == ACT_DEQ);
        end else if (low_count != '0) begin
          src_next   = SRC_LOW;
          class_next = CLASS_LOW;
          low_pop    = (op_action == ACT_DEQ);
        end else begin
          src_next    = SRC_NEG1;
          status_next = ST_EMPTY;
        end
      end
      default: begin
        // unused code: no state change, zero result
      end
    endcase
  end

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      high_rptr  <= '0;
      high_wptr  <= '0;
      high_count <= '0;
      low_rptr   <= '0;
      low_wptr   <= '0;
      low_count  <= '0;
    end else if (cmd.exec) begin
      if (high_push) begin
        high_wptr  <= (high_wptr == LAST_PTR) ? '0 : high_wptr + 1'b1;
        high_count <= high_count + 1'b1;
      end
      if (high_pop) begin
        high_rptr  <= (high_rptr == LAST_PTR) ? '0 : high_rptr + 1'b1;
        high_count <= high_count - 1'b1;
      end
      if (low_push) begin
        low_wptr  <= (low_wptr == LAST_PTR) ? '0 : low_wptr + 1'b1;
        low_count <= low_count + 1'b1;
      end
      if (low_pop) begin
        low_rptr  <= (low_rptr == LAST_PTR) ? '0 : low_rptr + 1'b1;
        low_count <= low_count - 1'b1;
      end
    end
  end

  // memory write and registered read of both heads
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (high_push) high_mem[high_wptr] <= op_word;
      if (low_push) low_mem[low_wptr] <= op_word;
      rd_high <= high_mem[high_rptr];
      rd_low  <= low_mem[low_rptr];
    end
  end

  // result bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_src    <= src_next;
      res_status <= status_next;
      res_class  <= class_next;
    end
  end

  // result word, sign-extended from DATA_WIDTH
  always_comb begin
    case (res_src)
      SRC_NEG1: result_value = '1;
      SRC_HIGH: result_value = VALUE_W'(rd_high);
      SRC_LOW:  result_value = VALUE_W'(rd_low);
      default:  result_value = '0;
    endcase
  end

  assign status       = res_status;
  assign served_class = res_class;

  `TCPQ_ASSERT(a_high_count_bound, clk, rst, high_count <= FULL_CNT)
  `TCPQ_ASSERT(a_low_count_bound, clk, rst, low_count <= FULL_CNT)
  `TCPQ_ASSERT(a_push_not_full, clk, rst, (cmd.exec && high_push) |-> high_count != FULL_CNT)

endmodule

`default_nettype wire

@@ design/two_class_priority_queue.sv @@
// Two-class strict-priority queue: two DEPTH-entry FIFOs, high class served first.
// A transaction accepted with start runs in the execute state, then its result is on
// the ports with done high for the next cycle. A new transaction may be accepted while
// done is high, but not during execute; busy is high only in the execute cycle,
// in which the latched transaction updates the FIFOs. done cannot be stalled.
// Reset (rst, synchronous): both FIFOs empty, pointers zero; memory contents are not cleared.
`default_nettype none

module two_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ACT_W-1:0]           action,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic                       priority_req,
  output logic                            done,
  output logic signed [VALUE_W-1:0]       result_value,
  output logic [STATUS_W-1:0]             status,
  output logic                            served_class
);

  tcpq_cmd_t cmd;

  tcpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tcpq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .value        (value),
    .priority_req (priority_req),
    .result_value (result_value),
    .status       (status),
    .served_class (served_class)
  );

endmodule

`default_nettype wire
